// ----- rtl/trd_pkg.sv -----
// shared types, constants and color scaling tables for the tga rle pixel decoder
package trd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 32;
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned PartialW  = 24;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [1:0]         pos_t;

  // configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    CFG_PIXEL_BYTES  = 1'b0,
    CFG_TOTAL_PIXELS = 1'b1
  } cfg_index_e;

  // pixel format, encoded as bytes per pixel minus one
  typedef enum logic [1:0] {
    MODE_RGB332   = 2'd0,
    MODE_RGB555A1 = 2'd1,
    MODE_BGR888   = 2'd2,
    MODE_BGRA8888 = 2'd3
  } pix_mode_e;

  localparam pix_mode_e ModeReset        = MODE_BGR888;
  localparam count_t    TotalPixelsReset = 32'd1;
  localparam byte_t     RunLenMax        = 8'd128;
  localparam byte_t     AlphaOpaque      = 8'hFF;

  localparam int unsigned FullScale  = 255;
  localparam int unsigned Pct        = 100;
  localparam int unsigned PctHalf    = 50;
  localparam int unsigned FieldMax8  = 255;

  // scaled values for 2, 3 and 5 bit fields, entry 0 rightmost
  localparam logic [3:0][7:0] Scale2Lut = {8'd255, 8'd171, 8'd87, 8'd0};
  localparam logic [7:0][7:0] Scale3Lut = {
    8'd255, 8'd219, 8'd184, 8'd145, 8'd110, 8'd74, 8'd36, 8'd0
  };
  localparam logic [31:0][7:0] Scale5Lut = {
    8'd255, 8'd247, 8'd240, 8'd230, 8'd222, 8'd214, 8'd207, 8'd196,
    8'd189, 8'd181, 8'd173, 8'd166, 8'd156, 8'd148, 8'd140, 8'd133,
    8'd122, 8'd115, 8'd107, 8'd99,  8'd92,  8'd82,  8'd74,  8'd66,
    8'd59,  8'd48,  8'd41,  8'd33,  8'd26,  8'd15,  8'd8,   8'd0
  };

  // 8 bit field through a rounded percentage, evaluated at elaboration
  function automatic logic [255:0][7:0] build_scale8();
    logic [255:0][7:0] lut;
    int unsigned c;
    int unsigned p;
    int unsigned q;
    int unsigned r;
    for (int v = 0; v < 256; v++) begin
      c = int'(v) * Pct;
      p = c / FieldMax8;
      if ((c % FieldMax8) >= (FieldMax8 / 2)) p = p + 1;
      q = p * FullScale;
      r = q / Pct;
      if ((q % Pct) >= PctHalf) r = r + 1;
      lut[v] = 8'(r);
    end
    return lut;
  endfunction

  localparam logic [255:0][7:0] Scale8Lut = build_scale8();

  // out-of-range byte counts clamp to the nearest format
  function automatic pix_mode_e mode_from_bytes(logic [2:0] bytes);
    pix_mode_e m;
    case (bytes) inside
      3'd0, 3'd1: m = MODE_RGB332;
      3'd2:       m = MODE_RGB555A1;
      3'd3:       m = MODE_BGR888;
      default:    m = MODE_BGRA8888;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/trd_if.sv -----
// valid/ready channel interfaces for the compressed byte stream and the decoded pixels
interface trd_in_if;
  logic            valid;
  logic            ready;
  trd_pkg::byte_t  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface trd_out_if;
  logic            valid;
  logic            ready;
  trd_pkg::byte_t  red;
  trd_pkg::byte_t  green;
  trd_pkg::byte_t  blue;
  trd_pkg::byte_t  alpha;
  trd_pkg::byte_t  repeat_res;
  logic            last_of_image;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_res, output last_of_image, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input repeat_res, input last_of_image, output ready);
endinterface

// ----- rtl/tga_rle_pixel_decoder.sv -----
// Run-length TGA pixel decoder: takes one compressed byte per request and, for every byte
// that completes a pixel, delivers one RGBA8 color with its repeat count from a result register.
// The block sustains one byte per clock while the receiver keeps up; the path from input
// byte to result register is a single pass through the color lookup tables and the 32-bit
// pixel-count subtract. A result that waits downstream holds off every input byte until it
// is taken, and a new byte can enter in the same cycle that the waiting result leaves. Header
// bytes and partial pixel bytes give no result. After the result flagged last_of_image the
// rest of the packet is dropped and the next byte is the header of a new image. Any
// configuration write restarts decoding at a packet header with the full pixel count.
module tga_rle_pixel_decoder (
  input  logic                              clk,
  input  logic                              rst,
  trd_in_if.sink                            in_ch,
  trd_out_if.source                         out_ch,
  input  logic                              cfg_write,
  input  logic [trd_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [trd_pkg::CfgDataW-1:0]      cfg_data
);
  import trd_pkg::*;

  // configuration
  pix_mode_e pixel_mode;
  count_t    total_eff;

  // decoder state
  logic                expect_header;
  logic                packet_is_run;
  byte_t               packet_left;
  pos_t                byte_position;
  logic [PartialW-1:0] pixel_partial;
  count_t              pixels_left;

  // result register
  logic  out_valid;
  byte_t red, green, blue, alpha, repeat_res;
  logic  last_of_image;

  logic                accept;
  logic                pixel_done;
  logic [31:0]         word;
  byte_t               red_next, green_next, blue_next, alpha_next;
  byte_t               rep_raw, rep_clip;
  count_t              pixels_after;
  logic                last_next;
  byte_t               packet_left_after;
  count_t              total_new;

  logic                expect_header_next;
  logic                packet_is_run_next;
  byte_t               packet_left_next;
  pos_t                byte_position_next;
  logic [PartialW-1:0] pixel_partial_next;
  count_t              pixels_left_next;

  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pixel_done  = !expect_header && (byte_position == pos_t'(pixel_mode));

  assign word = {8'b0, pixel_partial} | (32'(in_ch.in_byte) << {byte_position, 3'b000});

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    alpha_next = '0;
    case (pixel_mode)
      MODE_RGB332: begin
        blue_next  = Scale2Lut[word[1:0]];
        green_next = Scale3Lut[word[4:2]];
        red_next   = Scale3Lut[word[7:5]];
      end
      MODE_RGB555A1: begin
        blue_next  = Scale5Lut[word[4:0]];
        green_next = Scale5Lut[word[9:5]];
        red_next   = Scale5Lut[word[14:10]];
        alpha_next = word[15] ? AlphaOpaque : '0;
      end
      MODE_BGR888: begin
        blue_next  = word[7:0];
        green_next = word[15:8];
        red_next   = word[23:16];
      end
      MODE_BGRA8888: begin
        blue_next  = Scale8Lut[word[7:0]];
        green_next = Scale8Lut[word[15:8]];
        red_next   = Scale8Lut[word[23:16]];
        alpha_next = Scale8Lut[word[31:24]];
      end
      default: begin
        red_next = '0;
      end
    endcase
  end

  // repeat count, clipped to what is left of the image
  always_comb begin
    rep_raw = packet_is_run ? packet_left : 8'd1;
    if (rep_raw == '0) rep_raw = 8'd1;
    rep_clip     = (32'(rep_raw) > pixels_left) ? pixels_left[7:0] : rep_raw;
    pixels_after = pixels_left - 32'(rep_clip);
    last_next    = (pixels_after == '0);
    if (packet_is_run) begin
      packet_left_after = '0;
    end else begin
      packet_left_after = (packet_left != '0) ? packet_left - 8'd1 : '0;
    end
  end

  always_comb begin
    expect_header_next = expect_header;
    packet_is_run_next = packet_is_run;
    packet_left_next   = packet_left;
    byte_position_next = byte_position;
    pixel_partial_next = pixel_partial;
    pixels_left_next   = pixels_left;
    if (expect_header) begin
      packet_is_run_next = in_ch.in_byte[7];
      packet_left_next   = {1'b0, in_ch.in_byte[6:0]} + 8'd1;
      expect_header_next = 1'b0;
      byte_position_next = '0;
      pixel_partial_next = '0;
    end else if (!pixel_done) begin
      pixel_partial_next = word[PartialW-1:0];
      byte_position_next = byte_position + pos_t'(1);
    end else begin
      byte_position_next = '0;
      pixel_partial_next = '0;
      packet_left_next   = packet_left_after;
      pixels_left_next   = pixels_after;
      if (last_next) begin
        pixels_left_next   = total_eff;
        packet_left_next   = '0;
        expect_header_next = 1'b1;
      end else if (packet_left_after == '0) begin
        expect_header_next = 1'b1;
      end
    end
  end

  assign total_new = (cfg_data == '0) ? TotalPixelsReset : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode    <= ModeReset;
      total_eff     <= TotalPixelsReset;
      expect_header <= 1'b1;
      packet_is_run <= 1'b0;
      packet_left   <= '0;
      byte_position <= '0;
      pixel_partial <= '0;
      pixels_left   <= TotalPixelsReset;
    end else if (cfg_write) begin
      expect_header <= 1'b1;
      packet_is_run <= 1'b0;
      packet_left   <= '0;
      byte_position <= '0;
      pixel_partial <= '0;
      if (cfg_index == CFG_TOTAL_PIXELS) begin
        total_eff   <= total_new;
        pixels_left <= total_new;
      end else begin
        pixel_mode  <= mode_from_bytes(cfg_data[2:0]);
        pixels_left <= total_eff;
      end
    end else if (accept) begin
      expect_header <= expect_header_next;
      packet_is_run <= packet_is_run_next;
      packet_left   <= packet_left_next;
      byte_position <= byte_position_next;
      pixel_partial <= pixel_partial_next;
      pixels_left   <= pixels_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= accept && pixel_done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pixel_done) begin
      red           <= red_next;
      green         <= green_next;
      blue          <= blue_next;
      alpha         <= alpha_next;
      repeat_res    <= rep_clip;
      last_of_image <= last_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.red           = red;
  assign out_ch.green         = green;
  assign out_ch.blue          = blue;
  assign out_ch.alpha         = alpha;
  assign out_ch.repeat_res    = repeat_res;
  assign out_ch.last_of_image = last_of_image;

`ifndef SYNTHESIS
  // a restart always lands on a header with a loaded pixel count
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (expect_header && byte_position == '0 && pixels_left != '0))
    else $error("config write did not restart the decoder");

  a_pixels_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    pixels_left != '0)
    else $error("pixel count reached zero without reload");

  a_packet_bound: assert property (@(posedge clk) disable iff (rst)
    packet_left <= RunLenMax)
    else $error("packet length out of range");

  // end of image drops the packet and reloads the count
  a_end_of_image: assert property (@(posedge clk) disable iff (rst)
    (accept && pixel_done && last_next && !cfg_write) |=>
      (expect_header && packet_left == '0 && pixels_left == total_eff))
    else $error("end of image did not reload");

  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (repeat_res != '0 && repeat_res <= RunLenMax))
    else $error("repeat count out of range");
`endif

endmodule

// ----- sim/tga_rle_pixel_decoder_test.sv -----
// self-checking testbench for the tga rle pixel decoder with a built-in pixel predictor
`timescale 1ns / 100ps

module tga_rle_pixel_decoder_test;
  import trd_pkg::*;

  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    byte_t alpha;
    byte_t repeat_res;
    logic  last_img;
  } pixel_t;

  // tracks decoder state and holds the pixels still owed by the block
  class rle_pixel_board;
    logic [2:0]  pix_bytes_reg;
    count_t      total_reg;
    bit          hdr_wait;
    bit          run_pkt;
    int unsigned pkt_left;
    pos_t        pos;
    logic [23:0] partial;
    count_t      px_left;
    pixel_t      pending_pixels[$];
    int          errors;

    function new();
      pix_bytes_reg = 3'd3;
      total_reg     = TotalPixelsReset;
      errors        = 0;
      restart();
    endfunction

    function count_t eff_total();
      return (total_reg == 0) ? count_t'(1) : total_reg;
    endfunction

    function pix_mode_e pix_format();
      pix_mode_e m;
      case (pix_bytes_reg)
        3'd0, 3'd1: m = MODE_RGB332;
        3'd2:       m = MODE_RGB555A1;
        3'd3:       m = MODE_BGR888;
        default:    m = MODE_BGRA8888;
      endcase
      return m;
    endfunction

    function int bytes_per_pixel();
      return int'(pix_format()) + 1;
    endfunction

    function void restart();
      hdr_wait = 1;
      run_pkt  = 0;
      pkt_left = 0;
      pos      = '0;
      partial  = '0;
      px_left  = eff_total();
    endfunction

    function void write_reg(cfg_index_e idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_PIXEL_BYTES) begin
        pix_bytes_reg = val[2:0];
      end else begin
        total_reg = val;
      end
      restart();
    endfunction

    // k-bit field to 8 bits through a rounded percentage
    function byte_t scale(int unsigned v, int unsigned k);
      int unsigned m;
      int unsigned c;
      int unsigned p;
      int unsigned q;
      int unsigned r;
      m = (1 << k) - 1;
      c = (v & m) * 100;
      p = c / m;
      if ((c % m) >= (m / 2)) p++;
      q = p * 255;
      r = q / 100;
      if ((q % 100) >= 50) r++;
      return byte_t'(r);
    endfunction

    function void note_byte(byte_t b);
      pix_mode_e   m;
      int unsigned nb;
      logic [31:0] word;
      pixel_t      px;
      count_t      rep;
      m  = pix_format();
      nb = bytes_per_pixel();
      if (hdr_wait) begin
        run_pkt  = b[7];
        pkt_left = int'(b[6:0]) + 1;
        hdr_wait = 0;
        pos      = '0;
        partial  = '0;
        return;
      end
      if (int'(pos) + 1 < nb) begin
        partial = 24'({8'h00, partial} | (32'(b) << (8 * pos)));
        pos++;
        return;
      end
      word    = {8'h00, partial} | (32'(b) << (8 * pos));
      pos     = '0;
      partial = '0;
      case (m)
        MODE_RGB332: begin
          px.blue  = scale(word[1:0], 2);
          px.green = scale(word[4:2], 3);
          px.red   = scale(word[7:5], 3);
          px.alpha = 8'd0;
        end
        MODE_RGB555A1: begin
          px.blue  = scale(word[4:0], 5);
          px.green = scale(word[9:5], 5);
          px.red   = scale(word[14:10], 5);
          px.alpha = word[15] ? AlphaOpaque : 8'd0;
        end
        MODE_BGR888: begin
          px.blue  = word[7:0];
          px.green = word[15:8];
          px.red   = word[23:16];
          px.alpha = 8'd0;
        end
        default: begin
          px.blue  = scale(word[7:0], 8);
          px.green = scale(word[15:8], 8);
          px.red   = scale(word[23:16], 8);
          px.alpha = scale(word[31:24], 8);
        end
      endcase
      if (run_pkt) begin
        rep      = count_t'(pkt_left);
        pkt_left = 0;
      end else begin
        rep      = 1;
        pkt_left = (pkt_left > 0) ? pkt_left - 1 : 0;
      end
      if (rep == 0) rep = 1;
      if (rep > px_left) rep = px_left;
      px_left       = px_left - rep;
      px.repeat_res = rep[7:0];
      px.last_img   = (px_left == 0);
      // end of image drops the rest of the packet
      if (px.last_img) begin
        px_left  = eff_total();
        pkt_left = 0;
        hdr_wait = 1;
      end else if (pkt_left == 0) begin
        hdr_wait = 1;
      end
      pending_pixels.push_back(px);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel with nothing expected, expected none, got %h", $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      cmp_field("red", want.red, got.red);
      cmp_field("green", want.green, got.green);
      cmp_field("blue", want.blue, got.blue);
      cmp_field("alpha", want.alpha, got.alpha);
      cmp_field("repeat_res", want.repeat_res, got.repeat_res);
      cmp_field("last_of_image", want.last_img, got.last_img);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  trd_in_if  in_ch();
  trd_out_if out_ch();

  rle_pixel_board sb = new();

  bit tx_idle  = 1;
  bit rx_idle  = 1;
  bit hold_out = 0;

  tga_rle_pixel_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    int     stall;
    pixel_t got;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_out) begin
        out_ch.ready = 1'b0;
        repeat (200) @(negedge clk);
        hold_out = 0;
      end
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.red        = out_ch.red;
      got.green      = out_ch.green;
      got.blue       = out_ch.blue;
      got.alpha      = out_ch.alpha;
      got.repeat_res = out_ch.repeat_res;
      got.last_img   = out_ch.last_of_image;
      sb.check_pixel(got);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic push_byte(input byte_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic push_list(input byte_t seq[$]);
    foreach (seq[i]) push_byte(seq[i]);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // wait for every owed pixel, then let any header or partial byte clear the pipe
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid = 1'b0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed packets with random content, some noise and cut packets
  task automatic stream_packets(input int budget);
    int sent;
    int nb;
    bit is_run;
    int cnt;
    int body;
    sent = 0;
    nb   = sb.bytes_per_pixel();
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        push_byte(byte_t'($urandom));
        sent++;
      end else begin
        is_run = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) begin
          cnt = $urandom_range(64, 127);
          if (nb > 1) is_run = 1;
        end else begin
          cnt = $urandom_range(0, 7);
        end
        push_byte({is_run, 7'(cnt)});
        sent++;
        body = (is_run ? 1 : cnt + 1) * nb;
        if ($urandom_range(0, 9) == 0) body = $urandom_range(0, body);
        repeat (body) begin
          push_byte(byte_t'($urandom));
          sent++;
        end
      end
    end
    in_ch.valid = 1'b0;
  endtask

  initial begin
    logic [2:0]          pb;
    logic [CfgDataW-1:0] total;
    byte_t               burst[$];
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_PIXEL_BYTES;
    cfg_data      = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset format, one-pixel image
    push_list('{8'h00, 8'h10, 8'h20, 8'h30});
    settle();

    // total of zero acts as one: long run clipped, then the image restarts mid-packet
    write_reg(CFG_PIXEL_BYTES, 32'd1);
    write_reg(CFG_TOTAL_PIXELS, 32'd0);
    push_list('{8'hFF, 8'hE3, 8'h01, 8'h1C, 8'hFF});
    settle();

    // full 128 run, short run, raw packet with alpha bit both ways
    write_reg(CFG_PIXEL_BYTES, 32'd2);
    write_reg(CFG_TOTAL_PIXELS, 32'd300);
    push_list('{8'hFF, 8'hFF, 8'hFF, 8'h81, 8'hFF, 8'h7F,
                8'h02, 8'h00, 8'h80, 8'h1F, 8'h00, 8'hE0, 8'h03});
    settle();

    write_reg(CFG_PIXEL_BYTES, 32'd4);
    write_reg(CFG_TOTAL_PIXELS, 32'd4294836225);
    push_list('{8'h00, 8'h01, 8'h80, 8'hFE, 8'hFF});
    settle();

    // long result stall while requests keep coming back to back
    write_reg(CFG_PIXEL_BYTES, 32'd1);
    write_reg(CFG_TOTAL_PIXELS, 32'd1000);
    tx_idle  = 0;
    hold_out = 1;
    burst    = '{8'h3F};
    repeat (64) burst.push_back(byte_t'($urandom));
    push_list(burst);
    settle();

    for (int p = 0; p < 10; p++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pb = (p < 8) ? 3'((p + 1) % 8) : 3'($urandom_range(1, 4));
      case ($urandom_range(0, 5))
        0:       total = 32'd0;
        1:       total = 32'd4294836225;
        2:       total = $urandom;
        default: total = $urandom_range(1, 300);
      endcase
      write_reg(CFG_PIXEL_BYTES, 32'(pb));
      write_reg(CFG_TOTAL_PIXELS, total);
      stream_packets(40);
      settle();
    end

    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: pixels never delivered, expected 0 left, got %0d left",
               $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- tga_rle_pixel_decoder.f -----
rtl/trd_pkg.sv
rtl/trd_if.sv
rtl/tga_rle_pixel_decoder.sv
sim/tga_rle_pixel_decoder_test.sv
